@@ hdl/base45_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// base45 decoder assertion macros
// shared concurrent assertion forms for the base45 decoder modules
// ----------------------------------------------------------------------------
`ifndef BASE45_DECODER_ASSERT_SVH
`define BASE45_DECODER_ASSERT_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define B45_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("base45 decoder assertion failed");

// expression must never be true outside reset
`define B45_NEVER(label, clk, rst_n, expr) \
    `B45_ASSERT(label, clk, rst_n, !(expr))

`else

`define B45_ASSERT(label, clk, rst_n, prop)
`define B45_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ hdl/b45_pkg.sv @@
// ----------------------------------------------------------------------------
// b45_pkg
// types, codes and the character table shared by the base45 decoder
// ----------------------------------------------------------------------------
package b45_pkg;

    localparam int B45_RQ_DEPTH = 4;

    localparam int B45_CHAR_W = 8;
    localparam int B45_DIGIT_W = 6;
    localparam int B45_BYTE_W = 8;
    localparam int B45_PAIR_W = 11;
    localparam int B45_GROUP_W = 17;
    localparam int B45_CFG_IDX_W = 1;
    localparam int B45_CFG_DATA_W = 1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_DANGLING = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [B45_CFG_IDX_W-1:0] {
        CFG_ACCEPT_LOWERCASE = 1'd0,
        CFG_CHECK_OVERFLOW   = 1'd1
    } t_cfg_index;

    typedef struct packed {
        logic                  ok;
        logic [B45_DIGIT_W-1:0] value;
    } t_digit;

    typedef struct packed {
        logic [B45_BYTE_W-1:0] data_byte;
        logic                  end_of_message;
        t_status               status;
    } t_result;

    // up to two results from one character, first goes out first
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic t_digit digit_of(input logic [B45_CHAR_W-1:0] ch,
                                        input logic lower_ok);
        t_digit d;
        d.ok    = 1'b1;
        d.value = '0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            d.value = B45_DIGIT_W'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h5A) begin
            d.value = B45_DIGIT_W'(ch - 8'h41 + 8'd10);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            d.value = B45_DIGIT_W'(ch - 8'h61 + 8'd10);
            d.ok    = lower_ok;
        end else begin
            unique case (ch)
                8'h20:   d.value = 6'd36;
                8'h24:   d.value = 6'd37;
                8'h25:   d.value = 6'd38;
                8'h2A:   d.value = 6'd39;
                8'h2B:   d.value = 6'd40;
                8'h2D:   d.value = 6'd41;
                8'h2E:   d.value = 6'd42;
                8'h2F:   d.value = 6'd43;
                8'h3A:   d.value = 6'd44;
                default: d.ok    = 1'b0;
            endcase
        end
        return d;
    endfunction

endpackage

@@ hdl/b45_group.sv @@
// ----------------------------------------------------------------------------
// b45_group
// digit buffering, group arithmetic and error handling for one character
// ----------------------------------------------------------------------------
`include "base45_decoder_assert.svh"

module b45_group (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [b45_pkg::B45_CHAR_W-1:0]  i_char,
    input  logic                            i_last,
    input  logic                            i_accept_lowercase,
    input  logic                            i_check_overflow,
    output b45_pkg::t_push                  o_push
);
    import b45_pkg::*;

    logic [B45_DIGIT_W-1:0] r_first, n_first;
    logic [B45_DIGIT_W-1:0] r_second, n_second;
    logic [1:0]             r_count, n_count;
    logic                   r_discard, n_discard;

    t_digit                 w_digit;
    logic [B45_PAIR_W-1:0]  w_pair;
    logic [B45_GROUP_W-1:0] w_group;

    assign w_digit = digit_of(i_char, i_accept_lowercase);

    // final pair uses the incoming digit as its second digit
    assign w_pair  = {5'd0, r_first} + {5'd0, w_digit.value} * 11'd45;
    assign w_group = {11'd0, r_first}
                   + {11'd0, r_second} * 17'd45
                   + {11'd0, w_digit.value} * 17'd2025;

    always_comb begin
        n_first   = r_first;
        n_second  = r_second;
        n_count   = r_count;
        n_discard = r_discard;
        o_push    = '0;
        if (i_valid) begin
            if (r_discard) begin
                if (i_last) begin
                    n_discard = 1'b0;
                    n_count   = 2'd0;
                end
            end else if (!w_digit.ok) begin
                o_push.count = 2'd1;
                o_push.first = '{data_byte: '0, end_of_message: 1'b1,
                                 status: ST_BAD_CHAR};
                n_count   = 2'd0;
                n_discard = !i_last;
            end else if (r_count == 2'd0) begin
                n_first = w_digit.value;
                if (i_last) begin
                    o_push.count = 2'd1;
                    o_push.first = '{data_byte: '0, end_of_message: 1'b1,
                                     status: ST_DANGLING};
                end else begin
                    n_count = 2'd1;
                end
            end else if (r_count == 2'd1) begin
                n_second = w_digit.value;
                if (!i_last) begin
                    n_count = 2'd2;
                end else begin
                    n_count      = 2'd0;
                    o_push.count = 2'd1;
                    if (i_check_overflow && w_pair > 11'd255) begin
                        o_push.first = '{data_byte: '0, end_of_message: 1'b1,
                                         status: ST_OVERFLOW};
                    end else begin
                        o_push.first = '{data_byte: w_pair[7:0], end_of_message: 1'b1,
                                         status: ST_OK};
                    end
                end
            end else begin
                n_count = 2'd0;
                if (i_check_overflow && w_group > 17'd65535) begin
                    o_push.count = 2'd1;
                    o_push.first = '{data_byte: '0, end_of_message: 1'b1,
                                     status: ST_OVERFLOW};
                    n_discard    = !i_last;
                end else begin
                    o_push.count  = 2'd2;
                    o_push.first  = '{data_byte: w_group[15:8], end_of_message: 1'b0,
                                      status: ST_OK};
                    o_push.second = '{data_byte: w_group[7:0], end_of_message: i_last,
                                      status: ST_OK};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= '0;
            r_second  <= '0;
            r_count   <= '0;
            r_discard <= 1'b0;
        end else begin
            r_first   <= n_first;
            r_second  <= n_second;
            r_count   <= n_count;
            r_discard <= n_discard;
        end
    end

    `B45_NEVER(a_count_range, i_clk, i_rst_n, r_count == 2'd3)
    `B45_NEVER(a_discard_empty, i_clk, i_rst_n, r_discard && r_count != 2'd0)
    `B45_ASSERT(a_last_empties, i_clk, i_rst_n, (i_valid && i_last) |=> (r_count == 2'd0 && !r_discard))

endmodule

@@ hdl/b45_rq.sv @@
// ----------------------------------------------------------------------------
// b45_rq
// result queue taking up to two results a cycle and giving one
// ----------------------------------------------------------------------------
`include "base45_decoder_assert.svh"

module b45_rq #(
    parameter int DEPTH = b45_pkg::B45_RQ_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  b45_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_valid,
    output b45_pkg::t_result o_head,
    output logic             o_room2
);
    import b45_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result        r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  w_wr1;
    logic           w_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_wr1   = ptr_inc(r_wr);
    assign o_valid = (r_count != '0);
    assign w_pop   = i_pop && o_valid;
    assign o_head  = r_mem[r_rd];
    // space for a full group after this cycle's pop
    assign o_room2 = (r_count - CW'(w_pop)) <= CW'(DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.count == 2'd1) begin
                r_wr <= w_wr1;
            end else if (i_push.count == 2'd2) begin
                r_wr <= ptr_inc(w_wr1);
            end
            if (w_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            r_count <= r_count + CW'(i_push.count) - CW'(w_pop);
        end
    end

    `B45_NEVER(a_no_overfill, i_clk, i_rst_n, r_count > CW'(DEPTH))
    `B45_ASSERT(a_head_holds, i_clk, i_rst_n, (o_valid && !i_pop) |=> $stable(o_head))

endmodule

@@ hdl/base45_decoder.sv @@
// ----------------------------------------------------------------------------
// base45_decoder
// base45 text to byte stream decoder, one character per cycle
// ----------------------------------------------------------------------------
// takes one character per cycle with no gaps; a character is registered, then
// decoded by a table lookup and a constant multiply-add and written to the
// result queue, from which its bytes leave. every third character of a group
// adds two bytes unless it ends the message in an error, the others none or
// one; the input stalls only while the result queue (FIFO_DEPTH entries) has
// less than two free places, which happens only when the output side holds off.
`include "base45_decoder_assert.svh"

module base45_decoder #(
    parameter int FIFO_DEPTH = b45_pkg::B45_RQ_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [b45_pkg::B45_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [b45_pkg::B45_CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] char_code
    input  logic                               s_axis_tlast,   // last_char
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,   // [7:0] data_byte
    output logic                               m_axis_tlast,   // end_of_message
    output logic [1:0]                         m_axis_tuser    // [1:0] status
);
    import b45_pkg::*;

    logic                  r_accept_lowercase;
    logic                  r_check_overflow;
    logic                  r_in_valid;
    logic [B45_CHAR_W-1:0] r_in_char;
    logic                  r_in_last;

    logic    w_room2;
    logic    w_advance;
    t_push   w_push;
    t_result w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_lowercase <= 1'b1;
            r_check_overflow   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ACCEPT_LOWERCASE: r_accept_lowercase <= i_cfg_wdata[0];
                CFG_CHECK_OVERFLOW:   r_check_overflow   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_advance     = r_in_valid && w_room2;
    assign s_axis_tready = !r_in_valid || w_room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    b45_group u_group (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (w_advance),
        .i_char             (r_in_char),
        .i_last             (r_in_last),
        .i_accept_lowercase (r_accept_lowercase),
        .i_check_overflow   (r_check_overflow),
        .o_push             (w_push)
    );

    b45_rq #(
        .DEPTH (FIFO_DEPTH)
    ) u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (w_head),
        .o_room2 (w_room2)
    );

    assign m_axis_tdata = w_head.data_byte;
    assign m_axis_tlast = w_head.end_of_message;
    assign m_axis_tuser = w_head.status;

    `B45_NEVER(a_push_needs_item, i_clk, i_rst_n, w_push.count != 2'd0 && !w_advance)
    `B45_ASSERT(a_held_request, i_clk, i_rst_n, (r_in_valid && !w_room2) |=> (r_in_valid && $stable(r_in_char)))

endmodule

@@ tb/base45_checker.sv @@
// ----------------------------------------------------------------------------
// base45_checker
// watches both streams of the base45 decoder, predicts the decoded bytes of
// every accepted character and compares them, in order, with the results
// ----------------------------------------------------------------------------
module base45_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [b45_pkg::B45_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [b45_pkg::B45_CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [7:0]                         i_in_char,
    input  logic                               i_in_last,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [7:0]                         i_out_byte,
    input  logic                               i_out_eom,
    input  logic [1:0]                         i_out_status,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import b45_pkg::*;

    localparam int NO_DIGIT = -1;

    string      symbols = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";

    logic       lower_ok;
    logic       overflow_check;
    logic [5:0] first_dig;
    logic [5:0] second_dig;
    logic [1:0] held;
    logic       dropping;
    t_result    decoded_q[$];
    int         fail_total;

    function automatic int digit_value(input logic [7:0] ch);
        logic [7:0] up;
        int         k;
        up = (lower_ok && ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
        for (k = 0; k < 45; k++) begin
            if (8'(symbols[k]) == up) begin
                return k;
            end
        end
        return NO_DIGIT;
    endfunction

    function automatic void push_decoded(input logic [7:0] b, input logic eom,
                                         input t_status st);
        t_result r;
        r.data_byte      = b;
        r.end_of_message = eom;
        r.status         = st;
        decoded_q.push_back(r);
    endfunction

    // error ends the message: one result, rest of the message dropped
    function automatic void abort_message(input t_status st, input logic last);
        push_decoded(8'd0, 1'b1, st);
        held     = 2'd0;
        dropping = !last;
    endfunction

    function automatic void decode_char(input logic [7:0] ch, input logic last);
        int v;
        int x;
        if (dropping) begin
            if (last) begin
                dropping = 1'b0;
                held     = 2'd0;
            end
            return;
        end
        v = digit_value(ch);
        if (v == NO_DIGIT) begin
            abort_message(ST_BAD_CHAR, last);
            return;
        end
        case (held)
            2'd0: begin
                first_dig = 6'(v);
                if (last) begin
                    abort_message(ST_DANGLING, last);
                end else begin
                    held = 2'd1;
                end
            end
            2'd1: begin
                second_dig = 6'(v);
                if (!last) begin
                    held = 2'd2;
                end else begin
                    x = int'(first_dig) + 45 * int'(second_dig);
                    if (overflow_check && x > 255) begin
                        abort_message(ST_OVERFLOW, last);
                    end else begin
                        push_decoded(8'(x), 1'b1, ST_OK);
                        held = 2'd0;
                    end
                end
            end
            default: begin
                x = int'(first_dig) + 45 * int'(second_dig) + 2025 * v;
                if (overflow_check && x > 65535) begin
                    abort_message(ST_OVERFLOW, last);
                end else begin
                    push_decoded(8'(x >> 8), 1'b0, ST_OK);
                    push_decoded(8'(x), last, ST_OK);
                    held = 2'd0;
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            lower_ok       = 1'b1;
            overflow_check = 1'b1;
            first_dig      = '0;
            second_dig     = '0;
            held           = 2'd0;
            dropping       = 1'b0;
            fail_total     = 0;
            decoded_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_ACCEPT_LOWERCASE: lower_ok       = i_cfg_wdata[0];
                    CFG_CHECK_OVERFLOW:   overflow_check = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: data_byte %0h end_of_message %0b status %0d",
                           i_out_byte, i_out_eom, i_out_status);
                    fail_total++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out_byte !== want.data_byte) begin
                        $error("data_byte: expected %0h, got %0h", want.data_byte, i_out_byte);
                        fail_total++;
                    end
                    if (i_out_eom !== want.end_of_message) begin
                        $error("end_of_message: expected %0b, got %0b",
                               want.end_of_message, i_out_eom);
                        fail_total++;
                    end
                    if (i_out_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_out_status);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_char(i_in_char, i_in_last);
            end
        end
        o_pending    = decoded_q.size();
        o_fail_count = fail_total;
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// drives base45 text into the decoder under several register settings, with
// random gaps and stalls on both streams; the checker judges every result
// ----------------------------------------------------------------------------
module tb_top;
    import b45_pkg::*;

    localparam int CHARS_PER_PHASE  = 130;
    localparam int LONG_HOLD_AT     = 120;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 8;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [B45_CFG_IDX_W-1:0]  i_cfg_index;
    logic [B45_CFG_DATA_W-1:0] i_cfg_wdata;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata;   // [7:0] char_code
    logic                      s_axis_tlast;   // last_char
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [7:0]                m_axis_tdata;   // [7:0] data_byte
    logic                      m_axis_tlast;   // end_of_message
    logic [1:0]                m_axis_tuser;   // [1:0] status
    int                        fail_count;
    int                        pending;

    string      symbols = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";
    logic [7:0] msg_text[$];
    int         phase_chars;
    bit         tx_burst;
    bit         rx_burst;
    int         results_taken;

    base45_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    base45_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_char    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_byte   (m_axis_tdata),
        .i_out_eom    (m_axis_tlast),
        .i_out_status (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall per result, one long hold to back up the decoder
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        rx_burst      = 1'b0;
        results_taken = 0;
        do @(negedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 19);
            if (results_taken == LONG_HOLD_AT) gap = LONG_HOLD_CYCLES;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            results_taken++;
            @(negedge i_clk);
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        phase_chars++;
    endtask

    task automatic send_string(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            send_char(8'(s[k]), k == s.len() - 1);
        end
    endtask

    task automatic send_message();
        int k;
        for (k = 0; k < msg_text.size(); k++) begin
            send_char(msg_text[k], k == msg_text.size() - 1);
        end
    endtask

    // mostly properly encoded text, then raw digits, near-overflow groups and noise
    task automatic build_message();
        int kind;
        int n;
        int k;
        int v;
        msg_text.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 5 || kind == 9) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            for (k = 0; k < n; k += 2) begin
                if (k + 1 < n) begin
                    v = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 65535 : 0)
                                                    : $urandom_range(0, 65535);
                    msg_text.push_back(8'(symbols[v % 45]));
                    msg_text.push_back(8'(symbols[(v / 45) % 45]));
                    msg_text.push_back(8'(symbols[v / 2025]));
                end else begin
                    v = $urandom_range(0, 255);
                    msg_text.push_back(8'(symbols[v % 45]));
                    msg_text.push_back(8'(symbols[v / 45]));
                end
            end
            if (kind == 9) begin
                msg_text[$urandom_range(0, msg_text.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end else if (kind == 6) begin
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++) msg_text.push_back(8'(symbols[$urandom_range(0, 44)]));
        end else if (kind == 7) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
                msg_text.push_back(8'(symbols[$urandom_range(0, 44)]));
                msg_text.push_back(8'(symbols[$urandom_range(0, 44)]));
                msg_text.push_back(8'(symbols[$urandom_range(28, 44)]));
            end
            if ($urandom_range(0, 1)) begin
                msg_text.push_back(8'(symbols[$urandom_range(0, 44)]));
                msg_text.push_back(8'(symbols[$urandom_range(4, 8)]));
            end
        end else begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) msg_text.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) == 0) begin
            for (k = 0; k < msg_text.size(); k++) begin
                if (msg_text[k] >= 8'h41 && msg_text[k] <= 8'h5A && $urandom_range(0, 1))
                    msg_text[k] = msg_text[k] + 8'd32;
            end
        end
    endtask

    // drop valid, let every expected byte come out, then let the pipeline settle
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_ACCEPT_LOWERCASE;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        tx_burst      = 1'b0;
        phase_chars   = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: lowercase on, overflow checked
        send_string("FGW");    // largest group, ff ff
        send_string("U5");     // largest final pair
        send_string("00");
        send_string(":::");    // group overflow
        send_string("V5");     // final pair just over one byte
        send_string("A");      // dangling single character
        send_string("[");      // bad character as the last one
        send_string("{AB");    // bad character, rest of message dropped
        send_string("fgw");    // lowercase group
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);

        for (int p = 0; p < 4; p++) begin
            wait_idle();
            write_cfg(CFG_ACCEPT_LOWERCASE, p[0]);
            write_cfg(CFG_CHECK_OVERFLOW, p[1]);
            phase_chars = 0;
            while (phase_chars < CHARS_PER_PHASE) begin
                build_message();
                send_message();
            end
        end

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/b45_pkg.sv
hdl/b45_group.sv
hdl/b45_rq.sv
hdl/base45_decoder.sv
tb/base45_checker.sv
tb/tb_top.sv
